FILE: hw/rtl/vcrt_pkg.sv
package vcrt_pkg;

  localparam int VIDEO_DEPTH  = 16384;
  localparam int SPRITE_DEPTH = 256;
  localparam int VID_AW       = (VIDEO_DEPTH > 1) ? $clog2(VIDEO_DEPTH) : 1;
  localparam int SPR_AW       = (SPRITE_DEPTH > 1) ? $clog2(SPRITE_DEPTH) : 1;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_POLL  = 2'd3;

  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_OAMADDR = 3'd3;
  localparam logic [2:0] REG_OAMDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  localparam logic [8:0]  DOT_LAST     = 9'd340;
  localparam logic [8:0]  DOT_SPRITE0  = 9'd3;
  localparam logic [8:0]  LINE_SPRITE0 = 9'd1;
  localparam logic [8:0]  DOT_FLAG     = 9'd1;
  localparam logic [8:0]  LINE_VBLANK  = 9'd241;
  localparam logic [8:0]  LINE_WRAP    = 9'd261;
  localparam logic [13:0] BUFFER_LIMIT = 14'h3F00;
  localparam logic [13:0] STEP_WIDE    = 14'd32;
  localparam logic [13:0] STEP_NARROW  = 14'd1;

  // read data source in the result stage
  localparam logic [1:0] SRC_DIRECT     = 2'd0;
  localparam logic [1:0] SRC_SPRITE     = 2'd1;
  localparam logic [1:0] SRC_VIDEO_BUF  = 2'd2;
  localparam logic [1:0] SRC_VIDEO_DIRECT = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] reg_select;
    logic [7:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       nmi_fire;
    logic [8:0] line_now;
    logic [8:0] dot_now;
    logic [7:0] scroll_horiz;
    logic [7:0] scroll_vert;
  } out_item_t;

  typedef struct packed {
    logic [1:0] src;
    logic [7:0] direct;
    logic       spr_ok;
    logic       nmi_fire;
    logic [8:0] line;
    logic [8:0] dot;
    logic [7:0] sh;
    logic [7:0] sv;
  } stage_t;

  typedef struct packed {
    logic              vid_we;
    logic              vid_re;
    logic [VID_AW-1:0] vid_addr;
    logic              spr_we;
    logic              spr_re;
    logic [SPR_AW-1:0] spr_addr;
    logic [7:0]        wdata;
  } mem_req_t;

  // pointer modulo depth by compare and subtract
  function automatic logic [VID_AW-1:0] vid_index(input logic [13:0] p);
    logic [18:0] v;
    v = {5'd0, p};
    for (int k = 4; k >= 0; k--) begin
      if (v >= (19'(VIDEO_DEPTH) << k)) begin
        v = v - (19'(VIDEO_DEPTH) << k);
      end
    end
    return v[VID_AW-1:0];
  endfunction

  function automatic logic [SPR_AW-1:0] spr_index(input logic [7:0] p);
    logic [10:0] v;
    v = {3'd0, p};
    for (int k = 2; k >= 0; k--) begin
      if (v >= (11'(SPRITE_DEPTH) << k)) begin
        v = v - (11'(SPRITE_DEPTH) << k);
      end
    end
    return v[SPR_AW-1:0];
  endfunction

endpackage

FILE: hw/rtl/vcrt_if.sv
interface vcrt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [2:0] reg_select;
  logic [7:0] write_value;

  modport source(output valid, kind, reg_select, write_value, input ready);
  modport sink(input valid, kind, reg_select, write_value, output ready);
endinterface

interface vcrt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  logic       nmi_fire;
  logic [8:0] line_now;
  logic [8:0] dot_now;
  logic [7:0] scroll_horiz;
  logic [7:0] scroll_vert;

  modport source(output valid, read_value, nmi_fire, line_now, dot_now, scroll_horiz,
                 scroll_vert, input ready);
  modport sink(input valid, read_value, nmi_fire, line_now, dot_now, scroll_horiz,
               scroll_vert, output ready);
endinterface

FILE: hw/rtl/vcrt_ram.sv
module vcrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/vcrt_ctrl.sv
module vcrt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  vcrt_pkg::in_item_t item,
  output vcrt_pkg::stage_t   s0,
  output vcrt_pkg::mem_req_t mreq
);
  import vcrt_pkg::*;

  logic [8:0]  dot_r, dot_nxt, line_r, line_nxt, dot_inc;
  logic        sprite0_r, sprite0_nxt, vblank_r, vblank_nxt;
  logic        nmi_pend_r, nmi_pend_nxt, nmi_en_r, nmi_en_nxt;
  logic        step32_r, step32_nxt, exp_hi_r, exp_hi_nxt, exp_h_r, exp_h_nxt;
  logic [5:0]  hi_hold_r, hi_hold_nxt;
  logic [13:0] vptr_r, vptr_nxt, vstep;
  logic [7:0]  sptr_r, sptr_nxt, sh_r, sh_nxt, sv_r, sv_nxt;
  logic [SPRITE_DEPTH-1:0] spr_valid_r;

  always_comb begin
    dot_nxt      = dot_r;
    line_nxt     = line_r;
    sprite0_nxt  = sprite0_r;
    vblank_nxt   = vblank_r;
    nmi_pend_nxt = nmi_pend_r;
    nmi_en_nxt   = nmi_en_r;
    step32_nxt   = step32_r;
    exp_hi_nxt   = exp_hi_r;
    exp_h_nxt    = exp_h_r;
    hi_hold_nxt  = hi_hold_r;
    vptr_nxt     = vptr_r;
    sptr_nxt     = sptr_r;
    sh_nxt       = sh_r;
    sv_nxt       = sv_r;
    dot_inc      = dot_r + 9'd1;
    vstep        = step32_r ? STEP_WIDE : STEP_NARROW;
    mreq         = '0;
    mreq.vid_addr = vid_index(vptr_r);
    mreq.spr_addr = spr_index(sptr_r);
    mreq.wdata    = item.write_value;
    s0           = '0;
    s0.src       = SRC_DIRECT;
    if (accept) begin
      case (item.kind)
        KIND_TICK: begin
          if (dot_inc > DOT_LAST) begin
            dot_nxt  = '0;
            line_nxt = line_r + 9'd1;
          end else begin
            dot_nxt = dot_inc;
          end
          if (dot_nxt == DOT_SPRITE0 && line_nxt == LINE_SPRITE0) begin
            sprite0_nxt = 1'b1;
          end
          if (line_nxt == LINE_VBLANK && dot_nxt == DOT_FLAG) begin
            vblank_nxt   = 1'b1;
            sprite0_nxt  = 1'b0;
            nmi_pend_nxt = 1'b1;
          end else if (line_nxt == LINE_WRAP && dot_nxt == DOT_FLAG) begin
            vblank_nxt   = 1'b0;
            sprite0_nxt  = 1'b0;
            nmi_pend_nxt = 1'b0;
            line_nxt     = '0;
          end
        end
        KIND_WRITE: begin
          case (item.reg_select)
            REG_CTRL: begin
              step32_nxt = item.write_value[2];
              nmi_en_nxt = item.write_value[7];
            end
            REG_OAMADDR: sptr_nxt = item.write_value;
            REG_OAMDATA: begin
              mreq.spr_we = 1'b1;
              sptr_nxt    = sptr_r + 8'd1;
            end
            REG_SCROLL: begin
              if (exp_h_r) begin
                sh_nxt = item.write_value;
              end else begin
                sv_nxt = item.write_value;
              end
              exp_h_nxt = ~exp_h_r;
            end
            REG_ADDR: begin
              if (exp_hi_r) begin
                hi_hold_nxt = item.write_value[5:0];
                exp_hi_nxt  = 1'b0;
              end else begin
                vptr_nxt   = {hi_hold_r, item.write_value};
                exp_hi_nxt = 1'b1;
              end
            end
            REG_DATA: begin
              mreq.vid_we = 1'b1;
              vptr_nxt    = vptr_r + vstep;
            end
            default: ;
          endcase
        end
        KIND_READ: begin
          case (item.reg_select)
            REG_STATUS: begin
              s0.direct  = {vblank_r, sprite0_r, 6'd0};
              vblank_nxt = 1'b0;
            end
            REG_OAMDATA: begin
              mreq.spr_re = 1'b1;
              s0.src      = SRC_SPRITE;
              s0.spr_ok   = spr_valid_r[mreq.spr_addr];
            end
            REG_DATA: begin
              mreq.vid_re = 1'b1;
              vptr_nxt    = vptr_r + vstep;
              s0.src      = (vptr_r < BUFFER_LIMIT) ? SRC_VIDEO_BUF : SRC_VIDEO_DIRECT;
            end
            default: ;
          endcase
        end
        KIND_POLL: begin
          s0.nmi_fire  = nmi_en_r & nmi_pend_r;
          nmi_pend_nxt = 1'b0;
        end
        default: ;
      endcase
    end
    s0.line = line_nxt;
    s0.dot  = dot_nxt;
    s0.sh   = sh_nxt;
    s0.sv   = sv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r       <= '0;
      line_r      <= '0;
      sprite0_r   <= 1'b0;
      vblank_r    <= 1'b0;
      nmi_pend_r  <= 1'b0;
      nmi_en_r    <= 1'b0;
      step32_r    <= 1'b0;
      exp_hi_r    <= 1'b1;
      exp_h_r     <= 1'b1;
      hi_hold_r   <= '0;
      vptr_r      <= '0;
      sptr_r      <= '0;
      sh_r        <= '0;
      sv_r        <= '0;
      spr_valid_r <= '0;
    end else begin
      dot_r      <= dot_nxt;
      line_r     <= line_nxt;
      sprite0_r  <= sprite0_nxt;
      vblank_r   <= vblank_nxt;
      nmi_pend_r <= nmi_pend_nxt;
      nmi_en_r   <= nmi_en_nxt;
      step32_r   <= step32_nxt;
      exp_hi_r   <= exp_hi_nxt;
      exp_h_r    <= exp_h_nxt;
      hi_hold_r  <= hi_hold_nxt;
      vptr_r     <= vptr_nxt;
      sptr_r     <= sptr_nxt;
      sh_r       <= sh_nxt;
      sv_r       <= sv_nxt;
      if (mreq.spr_we) begin
        spr_valid_r[mreq.spr_addr] <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_timing_range: assert property (@(posedge clk) disable iff (!rst_n)
    dot_r <= DOT_LAST && line_r <= LINE_WRAP)
    else $error("dot or line counter out of range");

  a_poll_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.kind == KIND_POLL |=> !nmi_pend_r)
    else $error("nmi pending survived a poll");

  a_spr_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.spr_we |=> spr_valid_r[$past(mreq.spr_addr)])
    else $error("sprite entry not marked written");
`endif

endmodule

FILE: hw/rtl/vcrt_resp.sv
module vcrt_resp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  vcrt_pkg::stage_t s0,
  input  logic [7:0]       vid_rdata,
  input  logic [7:0]       spr_rdata,
  output logic             in_ready,
  vcrt_out_if.source       out_ch
);
  import vcrt_pkg::*;

  logic      s1_v_r, out_v_r, s1_adv;
  stage_t    s1_r;
  out_item_t out_r, out_nxt;
  logic [7:0] rbuf_r;

  assign s1_adv   = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ready = !s1_v_r || !out_v_r || out_ch.ready;

  always_comb begin
    out_nxt              = '0;
    out_nxt.nmi_fire     = s1_r.nmi_fire;
    out_nxt.line_now     = s1_r.line;
    out_nxt.dot_now      = s1_r.dot;
    out_nxt.scroll_horiz = s1_r.sh;
    out_nxt.scroll_vert  = s1_r.sv;
    case (s1_r.src)
      SRC_DIRECT:       out_nxt.read_value = s1_r.direct;
      SRC_SPRITE:       out_nxt.read_value = s1_r.spr_ok ? spr_rdata : 8'd0;
      SRC_VIDEO_BUF:    out_nxt.read_value = rbuf_r;
      SRC_VIDEO_DIRECT: out_nxt.read_value = vid_rdata;
      default:          out_nxt.read_value = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      rbuf_r  <= '0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
        if (s1_r.src == SRC_VIDEO_BUF) begin
          rbuf_r <= vid_rdata;
        end
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s0;
    end
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.read_value   = out_r.read_value;
  assign out_ch.nmi_fire     = out_r.nmi_fire;
  assign out_ch.line_now     = out_r.line_now;
  assign out_ch.dot_now      = out_r.dot_now;
  assign out_ch.scroll_horiz = out_r.scroll_horiz;
  assign out_ch.scroll_vert  = out_r.scroll_vert;

`ifndef NO_ASSERTIONS
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_v_r)
    else $error("accepted item lost before result stage");

  a_adv_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_v_r)
    else $error("result stage advanced without output");

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !(s1_v_r && !s1_adv))
    else $error("item accepted while result stage blocked");
`endif

endmodule

FILE: hw/rtl/video_chip_registers_and_timing_core.sv
// An accepted item passes the result stage register and then the output register.
// Throughput: one item per cycle until an output stall fills both result slots; each
// item makes at most one sprite or video RAM access; two result slots (RAM read stage
// and output register) absorb output stalls. Reset (rst_n low, synchronous) clears all
// counters, pointers and flags but sets the address and scroll write-order flags;
// sprite RAM reads as zero via per-entry valid bits, video RAM is undefined.
module video_chip_registers_and_timing_core (
  input  logic       clk,
  input  logic       rst_n,
  vcrt_in_if.sink    in_ch,
  vcrt_out_if.source out_ch
);
  import vcrt_pkg::*;

  logic     accept, in_ready;
  in_item_t item;
  stage_t   s0;
  mem_req_t mreq;
  logic [7:0] vid_rdata, spr_rdata;

  assign item.kind        = in_ch.kind;
  assign item.reg_select  = in_ch.reg_select;
  assign item.write_value = in_ch.write_value;
  assign in_ch.ready      = in_ready;
  assign accept           = in_ch.valid && in_ready;

  vcrt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .s0     (s0),
    .mreq   (mreq)
  );

  vcrt_ram #(
    .WIDTH (8),
    .DEPTH (VIDEO_DEPTH)
  ) u_vid_ram (
    .clk   (clk),
    .we    (mreq.vid_we),
    .waddr (mreq.vid_addr),
    .wdata (mreq.wdata),
    .re    (mreq.vid_re),
    .raddr (mreq.vid_addr),
    .rdata (vid_rdata)
  );

  vcrt_ram #(
    .WIDTH (8),
    .DEPTH (SPRITE_DEPTH)
  ) u_spr_ram (
    .clk   (clk),
    .we    (mreq.spr_we),
    .waddr (mreq.spr_addr),
    .wdata (mreq.wdata),
    .re    (mreq.spr_re),
    .raddr (mreq.spr_addr),
    .rdata (spr_rdata)
  );

  vcrt_resp u_resp (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .s0        (s0),
    .vid_rdata (vid_rdata),
    .spr_rdata (spr_rdata),
    .in_ready  (in_ready),
    .out_ch    (out_ch)
  );

endmodule
